FILE: rtl/open_addressing_hash_map_assert.svh
// Assertion macros for the hash map RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef OPEN_ADDRESSING_HASH_MAP_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_MAP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(name, ck, rn, cond, prop) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (prop)) \
        else $error("implication check failed");
`define ASSERT_NEXT(name, ck, rn, cond, prop) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(name, ck, rn, cond, prop)
`define ASSERT_NEXT(name, ck, rn, cond, prop)
`endif

`endif

FILE: rtl/oahm_pkg.sv
// Shared types, codes and the key mixing step of the hash map.
// Depends on nothing; used by every module of the block.
package oahm_pkg;

    localparam int KEY_W     = 64;
    localparam int FILL_W    = 11;
    localparam int MIX_STEPS = 7;

    localparam logic [FILL_W-1:0] FILL_RESET = 11'd768;

    // Register index as decoded from paddr[2].
    localparam logic CFG_FILL_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_LIVE  = 2'd1,
        SLOT_TOMB  = 2'd2
    } slot_state_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH,
        S_SWEEP
    } ctrl_state_t;

    typedef struct packed {
        logic state;
        logic pair;
    } store_we_t;

    // One step of the shift/add/xor cascade; seven steps make the full mix.
    function automatic logic [KEY_W-1:0] mix_step(input logic [KEY_W-1:0] v,
                                                  input logic [2:0] idx);
        logic [KEY_W-1:0] r;
        unique case (idx)
            3'd0:    r = (~v) + (v << 21);
            3'd1:    r = v ^ (v >> 24);
            3'd2:    r = v + (v << 3) + (v << 8);
            3'd3:    r = v ^ (v >> 14);
            3'd4:    r = v + (v << 2) + (v << 4);
            3'd5:    r = v ^ (v >> 28);
            3'd6:    r = v + (v << 31);
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/oahm_mix.sv
// Iterative key hash: one mixing step per cycle, then the home slot.
// Depends on oahm_pkg for the mixing step and key width.
module oahm_mix #(
    parameter int SLOTS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [63:0]                key,
    output logic                       done,
    output logic [$clog2(SLOTS)-1:0]   home
);

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam bit POW2      = (SLOTS & (SLOTS - 1)) == 0;
    localparam int MOD_STEPS = POW2 ? 0 : 8;
    localparam logic [3:0] LAST = 4'(oahm_pkg::MIX_STEPS + MOD_STEPS - 1);
    localparam logic [3:0] MIX_END = 4'(oahm_pkg::MIX_STEPS);

    logic [oahm_pkg::KEY_W-1:0] v_reg;
    logic [3:0]                 cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic                       in_mix;

    assign in_mix = cnt_reg < MIX_END;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == LAST);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                    run_reg <= 1'b0;
            end
        end
    end

    // After the mix, the word shifts out a byte at a time into the remainder.
    always_ff @(posedge clk)
    begin
        if (start)
            v_reg <= key;
        else if (run_reg)
        begin
            if (in_mix)
                v_reg <= oahm_pkg::mix_step(v_reg, cnt_reg[2:0]);
            else
                v_reg <= v_reg << 8;
        end
    end

    assign done = done_reg;

    generate
        if (POW2)
        begin : g_mask
            assign home = v_reg[SLOT_W-1:0];
        end
        else
        begin : g_mod
            localparam logic [SLOT_W:0] MODULUS = (SLOT_W + 1)'(SLOTS);

            logic [SLOT_W-1:0] r_reg;

            // Eight restoring steps: shift in one bit, subtract when over.
            function automatic logic [SLOT_W-1:0] mod_byte(input logic [SLOT_W-1:0] r,
                                                           input logic [7:0] b);
                logic [SLOT_W:0]   t;
                logic [SLOT_W-1:0] acc;
                acc = r;
                for (int i = 7; i >= 0; i--)
                begin
                    t = {acc, b[i]};
                    if (t >= MODULUS)
                        t = t - MODULUS;
                    acc = t[SLOT_W-1:0];
                end
                return acc;
            endfunction

            always_ff @(posedge clk)
            begin
                if (start)
                    r_reg <= '0;
                else if (run_reg && !in_mix)
                    r_reg <= mod_byte(r_reg, v_reg[63:56]);
            end

            assign home = r_reg;
        end
    endgenerate

endmodule

FILE: rtl/oahm_store.sv
// Slot storage: a 2-bit state per slot and the key/value pair per slot.
// Depends on oahm_pkg for the slot state code and write-enable struct.
module oahm_store #(
    parameter int SLOTS      = 1024,
    parameter int VALUE_BITS = 64
) (
    input  logic                        clk,
    input  logic [$clog2(SLOTS)-1:0]    rd_addr,
    input  oahm_pkg::store_we_t         we,
    input  logic [$clog2(SLOTS)-1:0]    wr_addr,
    input  oahm_pkg::slot_state_t       wr_state,
    input  logic [63:0]                 wr_key,
    input  logic [VALUE_BITS-1:0]       wr_value,
    output oahm_pkg::slot_state_t       rd_state,
    output logic [63:0]                 rd_key,
    output logic [VALUE_BITS-1:0]       rd_value
);

    localparam int PAIR_W = 64 + VALUE_BITS;

    oahm_pkg::slot_state_t state_mem [SLOTS];
    logic [PAIR_W-1:0]     pair_mem  [SLOTS];

    oahm_pkg::slot_state_t rd_state_reg;
    logic [PAIR_W-1:0]     rd_pair_reg;

    always_ff @(posedge clk)
    begin
        if (we.state)
            state_mem[wr_addr] <= wr_state;
        rd_state_reg <= state_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.pair)
            pair_mem[wr_addr] <= {wr_key, wr_value};
        rd_pair_reg <= pair_mem[rd_addr];
    end

    assign rd_state = rd_state_reg;
    assign rd_key   = rd_pair_reg[PAIR_W-1:VALUE_BITS];
    assign rd_value = rd_pair_reg[VALUE_BITS-1:0];

endmodule

FILE: rtl/open_addressing_hash_map.sv
// Top level of the linear-probing hash map: sequencer, count and register port.
// Depends on oahm_pkg, oahm_mix, oahm_store and the assertion macro header.
//
//  channel   | signals                                   | transfer
//  ----------+-------------------------------------------+---------------------------
//  command   | start, busy, opcode, key, value_in        | start high, busy low
//  result    | done, status, found, value_out, entry_total| done high, one cycle
//  register  | psel, penable, pwrite, paddr, pwdata, ... | access phase, pready high
//
// Put, get and remove hash the key, then probe P slots, one per cycle from the slot memory
// read port, then finish; the hash also reduces by a remainder when SLOTS is not a power
// of two. A new command may be accepted in the done cycle. Clear sweeps every slot.
// After reset the slot states are cleared in one pass with busy high; register writes
// are taken throughout. The receiver cannot stall results.
`include "open_addressing_hash_map_assert.svh"

module open_addressing_hash_map #(
    parameter int SLOTS      = 1024,
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [63:0] key,
    input  logic [63:0] value_in,
    output logic        done,
    output logic [1:0]  status,
    output logic        found,
    output logic [63:0] value_out,
    output logic [10:0] entry_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = ($clog2(SLOTS + 1) > oahm_pkg::FILL_W) ?
                            $clog2(SLOTS + 1) : oahm_pkg::FILL_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    oahm_pkg::ctrl_state_t state_reg, state_next;
    oahm_pkg::op_t         op_reg, op_next;
    oahm_pkg::status_t     status_reg, status_next;

    logic [63:0]            key_reg, key_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    logic [VALUE_BITS-1:0]  hitval_reg, hitval_next;
    logic [VALUE_BITS-1:0]  vout_reg, vout_next;
    logic [SLOT_W-1:0]      pos_reg, pos_next;
    logic [SLOT_W-1:0]      n_reg, n_next;
    logic [SLOT_W-1:0]      tomb_reg, tomb_next;
    logic [SLOT_W-1:0]      target_reg, target_next;
    logic [SLOT_W-1:0]      sweep_reg, sweep_next;
    logic                   tomb_valid_reg, tomb_valid_next;
    logic                   hit_reg, hit_next;
    logic                   spot_valid_reg, spot_valid_next;
    logic                   found_reg, found_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       live_reg, live_next;
    logic [oahm_pkg::FILL_W-1:0] fill_reg;

    logic                   mix_start;
    logic                   mix_done;
    logic [SLOT_W-1:0]      home;

    logic [SLOT_W-1:0]      rd_addr;
    logic [SLOT_W-1:0]      wr_addr;
    oahm_pkg::store_we_t    we;
    oahm_pkg::slot_state_t  wr_state;
    oahm_pkg::slot_state_t  rd_state;
    logic [63:0]            rd_key;
    logic [VALUE_BITS-1:0]  rd_value;

    logic [SLOT_W-1:0]      pos_wrap;
    logic [SLOT_W-1:0]      sweep_wrap;
    logic                   key_match;
    logic                   cfg_write;

    oahm_mix #(
        .SLOTS (SLOTS)
    ) u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .key   (key),
        .done  (mix_done),
        .home  (home)
    );

    oahm_store #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .we       (we),
        .wr_addr  (wr_addr),
        .wr_state (wr_state),
        .wr_key   (key_reg),
        .wr_value (val_reg),
        .rd_state (rd_state),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == oahm_pkg::CFG_FILL_LIMIT) ? 32'(fill_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= oahm_pkg::FILL_RESET;
        else if (cfg_write && (paddr[2] == oahm_pkg::CFG_FILL_LIMIT))
            fill_reg <= pwdata[oahm_pkg::FILL_W-1:0];
    end

    assign pos_wrap   = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign sweep_wrap = (sweep_reg == LAST_SLOT) ? '0 : sweep_reg + 1'b1;
    assign key_match  = rd_key == key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oahm_pkg::S_INIT;
            done_reg  <= 1'b0;
            live_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            live_reg  <= live_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        hitval_reg     <= hitval_next;
        vout_reg       <= vout_next;
        pos_reg        <= pos_next;
        n_reg          <= n_next;
        tomb_reg       <= tomb_next;
        target_reg     <= target_next;
        tomb_valid_reg <= tomb_valid_next;
        hit_reg        <= hit_next;
        spot_valid_reg <= spot_valid_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        hitval_next     = hitval_reg;
        vout_next       = vout_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        tomb_next       = tomb_reg;
        target_next     = target_reg;
        sweep_next      = sweep_reg;
        tomb_valid_next = tomb_valid_reg;
        hit_next        = hit_reg;
        spot_valid_next = spot_valid_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        live_next       = live_reg;
        done_next       = 1'b0;
        mix_start       = 1'b0;
        rd_addr         = '0;
        wr_addr         = target_reg;
        wr_state        = oahm_pkg::SLOT_EMPTY;
        we              = '0;

        unique case (state_reg)
            oahm_pkg::S_INIT:
            begin
                we.state   = 1'b1;
                wr_addr    = sweep_reg;
                sweep_next = sweep_wrap;
                if (sweep_reg == LAST_SLOT)
                    state_next = oahm_pkg::S_IDLE;
            end

            oahm_pkg::S_IDLE:
            begin
                // Address zero is read here so that a clear can start its sweep.
                if (start)
                begin
                    op_next  = oahm_pkg::op_t'(opcode);
                    key_next = key;
                    val_next = value_in[VALUE_BITS-1:0];
                    if (opcode == oahm_pkg::OP_CLEAR)
                    begin
                        sweep_next = '0;
                        state_next = oahm_pkg::S_SWEEP;
                    end
                    else
                    begin
                        mix_start  = 1'b1;
                        state_next = oahm_pkg::S_HASH;
                    end
                end
            end

            oahm_pkg::S_HASH:
            begin
                rd_addr = home;
                if (mix_done)
                begin
                    pos_next        = home;
                    n_next          = '0;
                    tomb_valid_next = 1'b0;
                    hit_next        = 1'b0;
                    spot_valid_next = 1'b0;
                    state_next      = oahm_pkg::S_PROBE;
                end
            end

            oahm_pkg::S_PROBE:
            begin
                // The next slot is read ahead while this one is judged.
                rd_addr  = pos_wrap;
                pos_next = pos_wrap;
                n_next   = n_reg + 1'b1;
                case (rd_state)
                    oahm_pkg::SLOT_LIVE:
                    begin
                        if (key_match)
                        begin
                            hit_next    = 1'b1;
                            target_next = pos_reg;
                            hitval_next = rd_value;
                            state_next  = oahm_pkg::S_FINISH;
                        end
                    end
                    oahm_pkg::SLOT_TOMB:
                    begin
                        if (!tomb_valid_reg)
                        begin
                            tomb_next       = pos_reg;
                            tomb_valid_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        spot_valid_next = 1'b1;
                        target_next     = tomb_valid_reg ? tomb_reg : pos_reg;
                        state_next      = oahm_pkg::S_FINISH;
                    end
                endcase
                // The whole table has been walked without a match or an empty slot.
                if ((state_next == oahm_pkg::S_PROBE) && (n_reg == LAST_SLOT))
                begin
                    spot_valid_next = tomb_valid_reg || (rd_state == oahm_pkg::SLOT_TOMB);
                    target_next     = tomb_valid_reg ? tomb_reg : pos_reg;
                    state_next      = oahm_pkg::S_FINISH;
                end
            end

            oahm_pkg::S_FINISH:
            begin
                done_next   = 1'b1;
                state_next  = oahm_pkg::S_IDLE;
                found_next  = hit_reg;
                vout_next   = '0;
                status_next = oahm_pkg::STAT_DONE;
                unique case (op_reg)
                    oahm_pkg::OP_PUT:
                    begin
                        if (hit_reg)
                            we.pair = 1'b1;
                        else if ((live_reg >= CNT_W'(fill_reg)) || !spot_valid_reg)
                            status_next = oahm_pkg::STAT_FULL;
                        else
                        begin
                            we.pair   = 1'b1;
                            we.state  = 1'b1;
                            wr_state  = oahm_pkg::SLOT_LIVE;
                            live_next = live_reg + 1'b1;
                        end
                    end
                    oahm_pkg::OP_GET:
                    begin
                        if (hit_reg)
                            vout_next = hitval_reg;
                        else
                            status_next = oahm_pkg::STAT_NOT_FOUND;
                    end
                    oahm_pkg::OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            we.state = 1'b1;
                            wr_state = oahm_pkg::SLOT_TOMB;
                            if (live_reg != '0)
                                live_next = live_reg - 1'b1;
                        end
                        else
                            status_next = oahm_pkg::STAT_NOT_FOUND;
                    end
                    default:
                    begin
                        status_next = oahm_pkg::STAT_DONE;
                    end
                endcase
            end

            oahm_pkg::S_SWEEP:
            begin
                // Live slots become empty; tombstones stay.
                rd_addr = sweep_wrap;
                wr_addr = sweep_reg;
                if (rd_state != oahm_pkg::SLOT_TOMB)
                    we.state = 1'b1;
                sweep_next = sweep_wrap;
                if (sweep_reg == LAST_SLOT)
                begin
                    live_next   = '0;
                    done_next   = 1'b1;
                    status_next = oahm_pkg::STAT_DONE;
                    found_next  = 1'b0;
                    vout_next   = '0;
                    state_next  = oahm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = oahm_pkg::S_IDLE;
            end
        endcase
    end

    assign busy        = state_reg != oahm_pkg::S_IDLE;
    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign value_out   = 64'(vout_reg);
    assign entry_total = oahm_pkg::FILL_W'(live_reg);

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done_reg, state_reg == oahm_pkg::S_IDLE)
    `ASSERT_IMPLIES(a_mix_in_hash, clk, rst_n, mix_done, state_reg == oahm_pkg::S_HASH)
    `ASSERT_IMPLIES(a_live_bound, clk, rst_n, 1'b1, live_reg <= CNT_W'(SLOTS))
    `ASSERT_IMPLIES(a_insert_limit, clk, rst_n, we.state && (wr_state == oahm_pkg::SLOT_LIVE), live_reg < CNT_W'(fill_reg))

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the open-addressing hash map: commands, results, fill limit.
// Depends on oahm_pkg and open_addressing_hash_map; keeps its own copy of the slot table.
module tb_top;

    localparam int NUM_SLOTS   = 1024;
    localparam int STALL_LIMIT = 10000;
    localparam int DRAIN_WAIT  = 20;
    localparam int FILL_TEST   = 64;
    localparam logic [2:0] FILL_LIMIT_ADDR = {oahm_pkg::CFG_FILL_LIMIT, 2'b00};

    typedef struct packed {
        oahm_pkg::status_t status;
        logic              found;
        logic [63:0]       value;
        logic [10:0]       total;
    } map_reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [63:0] value_in;
    logic        done;
    logic [1:0]  status;
    logic        found;
    logic [63:0] value_out;
    logic [10:0] entry_total;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the table, updated when each command is accepted.
    bit          slot_live [NUM_SLOTS];
    bit          slot_tomb [NUM_SLOTS];
    logic [63:0] slot_key_copy [NUM_SLOTS];
    logic [63:0] slot_value_copy [NUM_SLOTS];
    int          live_total = 0;
    logic [10:0] fill_cap = oahm_pkg::FILL_RESET;

    map_reply_t  reply_queue [$];
    int          fail_count = 0;
    int          burst_left = 0;
    int          stall_cycles = 0;

    open_addressing_hash_map dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .key         (key),
        .value_in    (value_in),
        .done        (done),
        .status      (status),
        .found       (found),
        .value_out   (value_out),
        .entry_total (entry_total),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int key_home(input logic [63:0] k);
        logic [63:0] h;
        h = (~k) + (k << 21);
        h = h ^ (h >> 24);
        h = h + (h << 3) + (h << 8);
        h = h ^ (h >> 14);
        h = h + (h << 2) + (h << 4);
        h = h ^ (h >> 28);
        h = h + (h << 31);
        return int'(h % 64'(NUM_SLOTS));
    endfunction

    // Random key whose probe run starts at the given slot.
    function automatic logic [63:0] key_at(input int home);
        logic [63:0] k;
        k = rand_word();
        while (key_home(k) != home)
            k = rand_word();
        return k;
    endfunction

    // Applies one command to the shadow table and returns the reply it must produce.
    function automatic map_reply_t apply_map_op(input oahm_pkg::op_t op,
                                                input logic [63:0] k,
                                                input logic [63:0] v);
        map_reply_t r;
        int pos;
        int hit;
        int spot;
        int first_tomb;
        int n;
        bit stop;
        r.status = oahm_pkg::STAT_DONE;
        r.found  = 1'b0;
        r.value  = '0;
        if (op == oahm_pkg::OP_CLEAR)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_live[i])
                begin
                    slot_live[i] = 1'b0;
                    slot_tomb[i] = 1'b0;
                end
            end
            live_total = 0;
        end
        else
        begin
            pos = key_home(k);
            hit = -1;
            spot = -1;
            first_tomb = -1;
            stop = 1'b0;
            for (n = 0; n < NUM_SLOTS && !stop; n++)
            begin
                if (!slot_live[pos])
                begin
                    if (!slot_tomb[pos])
                    begin
                        spot = (first_tomb >= 0) ? first_tomb : pos;
                        stop = 1'b1;
                    end
                    else if (first_tomb < 0)
                    begin
                        first_tomb = pos;
                    end
                end
                else if (slot_key_copy[pos] == k)
                begin
                    hit = pos;
                    stop = 1'b1;
                end
                if (!stop)
                    pos = (pos + 1) % NUM_SLOTS;
            end
            if (!stop)
                spot = first_tomb;
            r.found = (hit >= 0);
            case (op)
                oahm_pkg::OP_PUT:
                begin
                    if (hit >= 0)
                    begin
                        slot_value_copy[hit] = v;
                    end
                    else if (live_total >= fill_cap || spot < 0)
                    begin
                        r.status = oahm_pkg::STAT_FULL;
                    end
                    else
                    begin
                        slot_key_copy[spot] = k;
                        slot_value_copy[spot] = v;
                        slot_live[spot] = 1'b1;
                        slot_tomb[spot] = 1'b0;
                        live_total++;
                    end
                end
                oahm_pkg::OP_GET:
                begin
                    if (hit >= 0)
                        r.value = slot_value_copy[hit];
                    else
                        r.status = oahm_pkg::STAT_NOT_FOUND;
                end
                default:
                begin
                    if (hit >= 0)
                    begin
                        slot_live[hit] = 1'b0;
                        slot_tomb[hit] = 1'b1;
                        if (live_total > 0)
                            live_total--;
                    end
                    else
                    begin
                        r.status = oahm_pkg::STAT_NOT_FOUND;
                    end
                end
            endcase
        end
        r.total = live_total[10:0];
        return r;
    endfunction

    // Drives one command and waits for its transfer. Start is left high on return,
    // so a following command goes back to back unless the burst has run out.
    task automatic send_op(input oahm_pkg::op_t op, input logic [63:0] k,
                           input logic [63:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 12);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        start = 1'b1;
        opcode = op;
        key = k;
        value_in = v;
        do @(posedge clk); while (busy);
        reply_queue.push_back(apply_map_op(op, k, v));
    endtask

    task automatic hold_commands();
        @(negedge clk);
        start = 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        hold_commands();
        while (reply_queue.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic check_fill_limit();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = FILL_LIMIT_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {21'd0, fill_cap})
        begin
            $display("%0t fill_limit read: expected %0d, actual %0d", $time, fill_cap, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // The upper data bits carry noise; only the low eleven bits belong to the register.
    task automatic write_fill_limit(input logic [10:0] limit);
        logic [31:0] word;
        word = $urandom;
        word[10:0] = limit;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = FILL_LIMIT_ADDR;
        pwdata = word;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        fill_cap = limit;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        check_fill_limit();
    endtask

    task automatic test_reset_values();
        check_fill_limit();
        send_op(oahm_pkg::OP_GET, 64'd0, 64'd0);
        send_op(oahm_pkg::OP_REMOVE, '1, 64'd0);
        send_op(oahm_pkg::OP_CLEAR, rand_word(), rand_word());
    endtask

    task automatic test_basic_ops();
        send_op(oahm_pkg::OP_PUT, 64'd0, '1);
        send_op(oahm_pkg::OP_PUT, '1, 64'd0);
        send_op(oahm_pkg::OP_PUT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_op(oahm_pkg::OP_GET, 64'd0, rand_word());
        send_op(oahm_pkg::OP_GET, '1, rand_word());
        send_op(oahm_pkg::OP_PUT, 64'd0, 64'h0123_4567_89AB_CDEF);
        send_op(oahm_pkg::OP_GET, 64'd0, 64'd0);
        send_op(oahm_pkg::OP_REMOVE, '1, rand_word());
        send_op(oahm_pkg::OP_GET, '1, 64'd0);
        send_op(oahm_pkg::OP_REMOVE, '1, 64'd0);
        send_op(oahm_pkg::OP_PUT, '1, rand_word());
        send_op(oahm_pkg::OP_GET, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0);
        send_op(oahm_pkg::OP_CLEAR, 64'd0, 64'd0);
        send_op(oahm_pkg::OP_GET, 64'd0, 64'd0);
    endtask

    // Keys that share the last slot force the probe run to wrap to slot zero.
    task automatic test_probe_wrap();
        logic [63:0] ka;
        logic [63:0] kb;
        logic [63:0] kc;
        logic [63:0] kd;
        ka = key_at(NUM_SLOTS - 1);
        kb = key_at(NUM_SLOTS - 1);
        kc = key_at(NUM_SLOTS - 1);
        kd = key_at(NUM_SLOTS - 1);
        send_op(oahm_pkg::OP_PUT, ka, rand_word());
        send_op(oahm_pkg::OP_PUT, kb, rand_word());
        send_op(oahm_pkg::OP_PUT, kc, rand_word());
        send_op(oahm_pkg::OP_REMOVE, kb, 64'd0);
        send_op(oahm_pkg::OP_GET, kc, 64'd0);
        send_op(oahm_pkg::OP_PUT, kd, rand_word());
        send_op(oahm_pkg::OP_REMOVE, ka, 64'd0);
        send_op(oahm_pkg::OP_CLEAR, 64'd0, 64'd0);
        send_op(oahm_pkg::OP_PUT, ka, rand_word());
        send_op(oahm_pkg::OP_GET, ka, 64'd0);
    endtask

    task automatic test_fill_limits();
        logic [63:0] ka;
        logic [63:0] kb;
        ka = rand_word();
        kb = rand_word();
        send_op(oahm_pkg::OP_CLEAR, 64'd0, 64'd0);
        wait_drained();
        write_fill_limit(11'd0);
        send_op(oahm_pkg::OP_PUT, ka, rand_word());
        wait_drained();
        write_fill_limit(11'd1);
        send_op(oahm_pkg::OP_PUT, ka, rand_word());
        send_op(oahm_pkg::OP_PUT, kb, rand_word());
        send_op(oahm_pkg::OP_PUT, ka, '1);
        send_op(oahm_pkg::OP_GET, ka, 64'd0);
        wait_drained();
        write_fill_limit(11'd2047);
        send_op(oahm_pkg::OP_PUT, kb, rand_word());
    endtask

    // Fills the table up to a small fill limit, picking keys whose home slot is still
    // empty so that most probe runs stay one slot long; then a new key is refused.
    task automatic test_full_table();
        logic [63:0] k;
        logic [63:0] kept;
        int tries;
        int guard;
        send_op(oahm_pkg::OP_CLEAR, 64'd0, 64'd0);
        wait_drained();
        write_fill_limit(11'(FILL_TEST));
        guard = 0;
        kept = '0;
        while (live_total < FILL_TEST && guard < 2 * FILL_TEST)
        begin
            tries = 0;
            do
            begin
                k = rand_word();
                tries++;
            end
            while ((slot_live[key_home(k)] || slot_tomb[key_home(k)]) && tries < 20000);
            send_op(oahm_pkg::OP_PUT, k, rand_word());
            if (guard == 0)
                kept = k;
            guard++;
        end
        send_op(oahm_pkg::OP_PUT, rand_word(), rand_word());
        send_op(oahm_pkg::OP_GET, rand_word(), 64'd0);
        send_op(oahm_pkg::OP_PUT, kept, rand_word());
        send_op(oahm_pkg::OP_GET, kept, 64'd0);
        send_op(oahm_pkg::OP_REMOVE, kept, 64'd0);
        send_op(oahm_pkg::OP_PUT, rand_word(), rand_word());
        wait_drained();
        write_fill_limit(11'd1024);
        send_op(oahm_pkg::OP_PUT, rand_word(), rand_word());
        send_op(oahm_pkg::OP_CLEAR, 64'd0, 64'd0);
        wait_drained();
        write_fill_limit(oahm_pkg::FILL_RESET);
    endtask

    task automatic test_random_traffic();
        logic [63:0] key_pool [40];
        logic [10:0] limits [4];
        logic [63:0] k;
        logic [63:0] v;
        oahm_pkg::op_t op;
        int pick;
        int home;
        limits[0] = oahm_pkg::FILL_RESET;
        limits[1] = 11'd16;
        limits[2] = 11'd2047;
        limits[3] = 11'd1;
        for (int i = 0; i < 24; i++)
            key_pool[i] = rand_word();
        // Four groups of four keys on adjacent home slots build long clusters.
        for (int g = 0; g < 4; g++)
        begin
            home = $urandom_range(0, NUM_SLOTS - 1);
            for (int j = 0; j < 4; j++)
                key_pool[24 + 4 * g + j] = key_at((home + j / 2) % NUM_SLOTS);
        end
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            write_fill_limit(limits[phase]);
            for (int n = 0; n < 100; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    op = oahm_pkg::OP_PUT;
                else if (pick < 75)
                    op = oahm_pkg::OP_GET;
                else if (pick < 98)
                    op = oahm_pkg::OP_REMOVE;
                else
                    op = oahm_pkg::OP_CLEAR;
                if ($urandom_range(0, 9) == 0)
                    k = rand_word();
                else
                    k = key_pool[$urandom_range(0, 39)];
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    v = '0;
                else if (pick == 1)
                    v = '1;
                else
                    v = rand_word();
                send_op(op, k, v);
            end
        end
    endtask

    always @(posedge clk)
    begin
        map_reply_t want;
        if (rst_n && done)
        begin
            if (reply_queue.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual status %0d total %0d",
                         $time, status, entry_total);
                fail_count++;
            end
            else
            begin
                want = reply_queue.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t status: expected %0d, actual %0d", $time, want.status, status);
                    fail_count++;
                end
                if (found !== want.found)
                begin
                    $display("%0t found: expected %0b, actual %0b", $time, want.found, found);
                    fail_count++;
                end
                if (value_out !== want.value)
                begin
                    $display("%0t value_out: expected %h, actual %h", $time, want.value,
                             value_out);
                    fail_count++;
                end
                if (entry_total !== want.total)
                begin
                    $display("%0t entry_total: expected %0d, actual %0d", $time, want.total,
                             entry_total);
                    fail_count++;
                end
            end
        end
    end

    // Any transfer on a channel counts as progress.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        start = 1'b0;
        opcode = oahm_pkg::OP_PUT;
        key = '0;
        value_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_tomb[i] = 1'b0;
            slot_key_copy[i] = '0;
            slot_value_copy[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_basic_ops();
        test_probe_wrap();
        test_fill_limits();
        test_full_table();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
